@@ rtl/source_address_packet_counter_unit_assert.svh @@
// Assertion macros used by the packet counter sequencer.
`ifndef SOURCE_ADDRESS_PACKET_COUNTER_UNIT_ASSERT_SVH
`define SOURCE_ADDRESS_PACKET_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SAPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sapc: assertion failed");

// Next-cycle implication, disabled while in reset.
`define SAPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sapc: assertion failed");

`endif

@@ rtl/sapc_pkg.sv @@
// Types and constants of the source address packet counter.
`timescale 1ns / 1ps

package sapc_pkg;

  localparam int unsigned ADDR_W           = 32;
  localparam int unsigned COUNT_W          = 32;
  localparam int unsigned WORD_W           = ADDR_W + COUNT_W;
  localparam int unsigned USED_OUT_W       = 9;
  localparam int unsigned MIN_HEADER_BYTES = 20;
  localparam int unsigned BYTES_PER_WORD   = 4;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RDWAIT,
    S_SHIFT,
    S_INSERT,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e                 status;
    logic [COUNT_W-1:0]      count;
    logic [ADDR_W-1:0]       addr;
    logic [USED_OUT_W-1:0]   used;
  } res_t;

endpackage

@@ rtl/sapc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sapc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sapc_ctrl.sv @@
// Sequencer: ordered scan, in-place shift and update of the address table.
`timescale 1ns / 1ps
`include "source_address_packet_counter_unit_assert.svh"

module sapc_ctrl #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       cmd_i,
  input  logic [3:0]                       header_words_i,
  input  logic [sapc_pkg::ADDR_W-1:0]      address_i,
  input  logic [7:0]                       entry_index_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output sapc_pkg::res_t                   res_o,
  output logic                             ram_we_o,
  output logic [$clog2(ENTRIES)-1:0]       ram_waddr_o,
  output logic [sapc_pkg::WORD_W-1:0]      ram_wdata_o,
  output logic [$clog2(ENTRIES)-1:0]       ram_raddr_o,
  input  logic [sapc_pkg::WORD_W-1:0]      ram_rdata_i
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  sapc_pkg::state_e                 state_q, state_d;
  logic [1:0]                       cmd_q, cmd_d;
  logic [sapc_pkg::ADDR_W-1:0]      addr_q, addr_d;
  logic [CW-1:0]                    idx_q, idx_d;
  logic [CW-1:0]                    used_q, used_d;
  logic [CW-1:0]                    k_q, k_d;
  logic [CW-1:0]                    rem_q, rem_d;
  logic                             pend_q, pend_d;
  logic [AW-1:0]                    wa_q, wa_d;
  sapc_pkg::status_e                st_q, st_d;
  logic [sapc_pkg::COUNT_W-1:0]     cnt_q, cnt_d;
  logic [sapc_pkg::ADDR_W-1:0]      eaddr_q, eaddr_d;

  logic [sapc_pkg::ADDR_W-1:0]      d_addr;
  logic [sapc_pkg::COUNT_W-1:0]     d_cnt;
  logic [sapc_pkg::COUNT_W-1:0]     d_cnt_inc;
  logic                             scan_end, scan_hit, scan_below, short_hdr;

  assign d_addr    = ram_rdata_i[sapc_pkg::WORD_W-1 -: sapc_pkg::ADDR_W];
  assign d_cnt     = ram_rdata_i[sapc_pkg::COUNT_W-1:0];
  assign d_cnt_inc = (d_cnt == '1) ? d_cnt : d_cnt + 1'b1;
  assign scan_end   = (idx_q >= used_q);
  assign scan_hit   = !scan_end && (d_addr == addr_q);
  assign scan_below = !scan_end && (d_addr < addr_q);
  assign short_hdr  = ({header_words_i, 2'b00} <
                       6'(sapc_pkg::MIN_HEADER_BYTES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sapc_pkg::S_IDLE;
      used_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    addr_q  <= addr_d;
    idx_q   <= idx_d;
    k_q     <= k_d;
    rem_q   <= rem_d;
    wa_q    <= wa_d;
    st_q    <= st_d;
    cnt_q   <= cnt_d;
    eaddr_q <= eaddr_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    idx_d       = idx_q;
    used_d      = used_q;
    k_d         = k_q;
    rem_d       = rem_q;
    pend_d      = 1'b0;
    wa_d        = wa_q;
    st_d        = st_q;
    cnt_d       = cnt_q;
    eaddr_d     = eaddr_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = wa_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = '0;

    case (state_q)
      sapc_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        ram_raddr_o = (cmd_i == sapc_pkg::CMD_READ) ? AW'(entry_index_i) : '0;
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          addr_d  = address_i;
          idx_d   = '0;
          cnt_d   = '0;
          eaddr_d = '0;
          st_d    = sapc_pkg::ST_MISS;
          state_d = sapc_pkg::S_DONE;
          case (cmd_i)
            sapc_pkg::CMD_RECORD: begin
              if (short_hdr) begin
                st_d = sapc_pkg::ST_SHORT;
              end else begin
                state_d = sapc_pkg::S_SCAN;
              end
            end
            sapc_pkg::CMD_QUERY: begin
              state_d = sapc_pkg::S_SCAN;
            end
            sapc_pkg::CMD_READ: begin
              if (32'(entry_index_i) < 32'(used_q)) begin
                state_d = sapc_pkg::S_RDWAIT;
              end
            end
            default: begin
              st_d = sapc_pkg::ST_MISS;
            end
          endcase
        end
      end

      sapc_pkg::S_SCAN: begin
        // data for entry idx_q is on the read port; fetch the next one
        ram_raddr_o = AW'(idx_q + 1'b1);
        if (scan_hit) begin
          st_d    = sapc_pkg::ST_OK;
          eaddr_d = d_addr;
          state_d = sapc_pkg::S_DONE;
          if (cmd_q == sapc_pkg::CMD_RECORD) begin
            cnt_d       = d_cnt_inc;
            ram_we_o    = 1'b1;
            ram_waddr_o = AW'(idx_q);
            ram_wdata_o = {d_addr, d_cnt_inc};
          end else begin
            cnt_d = d_cnt;
          end
        end else if (scan_end || scan_below) begin
          if (cmd_q != sapc_pkg::CMD_RECORD) begin
            st_d    = sapc_pkg::ST_MISS;
            state_d = sapc_pkg::S_DONE;
          end else if (used_q == CW'(ENTRIES)) begin
            st_d    = sapc_pkg::ST_FULL;
            state_d = sapc_pkg::S_DONE;
          end else begin
            // idx_q is the insert position; move the tail up one slot
            k_d     = used_q - 1'b1;
            rem_d   = used_q - idx_q;
            state_d = sapc_pkg::S_SHIFT;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      sapc_pkg::S_RDWAIT: begin
        st_d    = sapc_pkg::ST_OK;
        cnt_d   = d_cnt;
        eaddr_d = d_addr;
        state_d = sapc_pkg::S_DONE;
      end

      sapc_pkg::S_SHIFT: begin
        // read k, write k+1 in the following cycle: the read always leads the write
        ram_raddr_o = AW'(k_q);
        ram_we_o    = pend_q;
        ram_waddr_o = wa_q;
        ram_wdata_o = ram_rdata_i;
        if (rem_q != '0) begin
          k_d    = k_q - 1'b1;
          rem_d  = rem_q - 1'b1;
          pend_d = 1'b1;
          wa_d   = AW'(k_q + 1'b1);
        end else if (!pend_q) begin
          state_d = sapc_pkg::S_INSERT;
        end
      end

      sapc_pkg::S_INSERT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'(idx_q);
        ram_wdata_o = {addr_q, sapc_pkg::COUNT_W'(1)};
        used_d      = used_q + 1'b1;
        st_d        = sapc_pkg::ST_OK;
        cnt_d       = sapc_pkg::COUNT_W'(1);
        eaddr_d     = addr_q;
        state_d     = sapc_pkg::S_DONE;
      end

      sapc_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = sapc_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sapc_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o.status = st_q;
  assign res_o.count  = cnt_q;
  assign res_o.addr   = eaddr_q;
  assign res_o.used   = sapc_pkg::USED_OUT_W'(used_q);

  `SAPC_ASSERT_IMPL(a_used_bound, 1'b1, used_q <= CW'(ENTRIES))
  `SAPC_ASSERT_IMPL(a_idle_no_write, state_q == sapc_pkg::S_IDLE, !ram_we_o)
  `SAPC_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, state_q != sapc_pkg::S_IDLE)
  `SAPC_ASSERT_NEXT(a_insert_grows, state_q == sapc_pkg::S_INSERT, used_q == CW'($past(used_q) + 1'b1))

endmodule

@@ rtl/source_address_packet_counter_unit.sv @@
// Top level of the per-source-address packet counter.
`timescale 1ns / 1ps

// Keeps up to ENTRIES distinct source addresses, held in descending order in
// one synchronous RAM word per entry ({address, count}), each with a count.
// Input channel (in_valid_i / in_ready_o) carries one command beat:
//   record (short headers dropped, known address counted with saturation,
//   new address inserted in order unless full), query by address, or read by position.
// Output channel (out_valid_o / out_ready_i) returns exactly one result beat
// per command, from an output register.
// A query scan stops at the first entry not above the address. Recording a
// new address takes one RAM pass over the table: the scan runs down to the
// insert point and the shift moves the tail above it up a slot, one entry per
// cycle over the single read and write ports.
// One command is worked on at a time; the next beat is taken as soon as the
// previous result has moved into the output register.
// Reset clears the entry count but not the RAM; RAM contents need no clearing
// since only data read from positions below the count is ever used.
// A stalled receiver holds the output register; a finished result then
// waits in the sequencer and no new beat is taken until it moves on.

module source_address_packet_counter_unit #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  header_words_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] packet_count_o,
  output logic [31:0] entry_address_o,
  output logic [8:0]  entries_used_o
);

  localparam int unsigned AW = $clog2(ENTRIES);

  // RAM port wiring
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [AW-1:0]                  ram_raddr;
  logic [sapc_pkg::WORD_W-1:0]    ram_wdata;
  logic [sapc_pkg::WORD_W-1:0]    ram_rdata;

  // Result handover from the sequencer
  logic                           res_valid;
  logic                           res_ready;
  sapc_pkg::res_t                 res;

  // Output register
  logic                           out_valid_q, out_valid_d;
  sapc_pkg::res_t                 out_q;

  sapc_ram #(
    .WIDTH (sapc_pkg::WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sapc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .header_words_i (header_words_i),
    .address_i      (address_i),
    .entry_index_i  (entry_index_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  // Register slot is free when empty or being drained this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign packet_count_o  = out_q.count;
  assign entry_address_o = out_q.addr;
  assign entries_used_o  = out_q.used;

endmodule
